// ===== design/dpce_pkg.sv =====
// Types and constants shared by the delta prefix-code encoder.
package dpce_pkg;

	localparam int TOTAL_BITS_WIDTH = 19;
	localparam int SAMPLE_WIDTH     = 16;
	localparam int CFG_DATA_WIDTH   = 60;
	localparam int CFG_INDEX_WIDTH  = 2;
	localparam int MAP_LOW_WIDTH    = 60;
	localparam int MAP_HIGH_WIDTH   = 25;
	localparam int MAP_ENTRY_WIDTH  = 5;
	localparam int BIN_WIDTH        = 5;
	localparam int PREFIX_WIDTH     = 14;
	localparam int PREFIX_LEN_WIDTH = 4;
	localparam int ACC_WIDTH        = 40;
	localparam int MAX_RESULTS      = 5;
	localparam int CNT_WIDTH        = 3;

	localparam logic [CFG_INDEX_WIDTH-1:0] CFG_MAP_ENABLE = 2'd0;
	localparam logic [CFG_INDEX_WIDTH-1:0] CFG_MAP_LOW    = 2'd1;
	localparam logic [CFG_INDEX_WIDTH-1:0] CFG_MAP_HIGH   = 2'd2;

	localparam logic [MAP_ENTRY_WIDTH-1:0] MAX_CODE = 5'd16;

	// three-bit prefixes for bins 1..5, sent LSB first
	localparam logic [2:0] LOW_PREFIX [0:5] = '{3'h0, 3'h2, 3'h6, 3'h1, 3'h5, 3'h3};

	typedef struct packed {
		logic signed [SAMPLE_WIDTH-1:0] sample;
		logic                           last_sample;
	} in_word_t;

	typedef struct packed {
		logic [7:0]                  out_byte;
		logic                        byte_valid;
		logic                        run_last;
		logic                        block_end;
		logic [TOTAL_BITS_WIDTH-1:0] block_bits;
	} out_word_t;

endpackage

// ===== design/delta_prefix_code_encoder.sv =====
// Top level of the delta prefix-code encoder: delta, bin, prefix and byte packing.
//
// Input words carry a signed 16-bit sample and a last_sample flag over valid/ready.
// Each sample is differenced against the previous one of its block, coded as a
// prefix for its bin followed by bin index bits, and packed LSB first into bytes.
// Output words carry at most one byte each; run_last marks the final word caused by a
// sample, block_end marks the end of a block together with the saturating bit count.
// A sample that completes no byte and is not last gives no output word.
// Throughput: the coding is combinational between the input register and the
// byte shifter; a sample then holds the shifter until it has given all its
// output words (zero to five), so the output channel at one word per cycle sets
// the rate while out_ready holds, one sample per cycle at best.
// When the receiver stalls, the shifter holds its word and one further sample
// waits in the input register; in_ready falls once both are full.
// Reset clears the block state and the map registers; the user writes configuration
// through cfg_we/cfg_index/cfg_data only while the block is idle, which the block leaves unchecked.
module delta_prefix_code_encoder (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  dpce_pkg::in_word_t                   in_word,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output dpce_pkg::out_word_t                  out_word,
	input  logic                                 cfg_we,
	input  logic [dpce_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
	input  logic [dpce_pkg::CFG_DATA_WIDTH-1:0]  cfg_data
);

	localparam int TBW = dpce_pkg::TOTAL_BITS_WIDTH;
	localparam int SW  = dpce_pkg::SAMPLE_WIDTH;
	localparam int AW  = dpce_pkg::ACC_WIDTH;
	localparam int BW  = dpce_pkg::BIN_WIDTH;
	localparam int EW  = dpce_pkg::MAP_ENTRY_WIDTH;
	localparam int PW  = dpce_pkg::PREFIX_WIDTH;
	localparam int LW  = dpce_pkg::PREFIX_LEN_WIDTH;
	localparam int CW  = dpce_pkg::CNT_WIDTH;
	localparam logic [TBW-1:0] TOTAL_MAX = {TBW{1'b1}};

	// configuration
	logic                                map_enable_q;
	logic [dpce_pkg::MAP_LOW_WIDTH-1:0]  map_low_q;
	logic [dpce_pkg::MAP_HIGH_WIDTH-1:0] map_high_q;

	// block state
	logic [SW-1:0]  prev_q;
	logic [7:0]     pend_bits_q;
	logic [2:0]     pend_cnt_q;
	logic [TBW-1:0] bit_total_q;

	// input register
	logic          valid_s1;
	logic [SW-1:0] sample_s1;
	logic          last_s1;

	// byte shifter
	logic [AW-1:0]  acc_q;
	logic [CW-1:0]  cnt_q;
	logic           last_q;
	logic           flush_q;
	logic [TBW-1:0] total_q;

	logic                         xfer;
	logic [SW-1:0]                delta;
	logic                         neg;
	logic [SW:0]                  mag;
	logic [BW-1:0]                bin;
	logic [SW:0]                  idx_full;
	logic [SW-1:0]                idx;
	logic [dpce_pkg::MAP_LOW_WIDTH+dpce_pkg::MAP_HIGH_WIDTH-1:0] entries;
	logic [6:0]                   ent_pos;
	logic [EW-1:0]                ent_raw;
	logic [EW-1:0]                code;
	logic [PW-1:0]                pval;
	logic [LW-1:0]                plen;
	logic [7:0]                   pend_mask;
	logic [AW-1:0]                acc;
	logic [BW-1:0]                added;
	logic [5:0]                   ntot;
	logic [2:0]                   full;
	logic [7:0]                   pend_next;
	logic [TBW:0]                 sum;
	logic [TBW-1:0]               total_sat;
	logic                         final_word;
	logic                         bare_end;

	assign xfer     = valid_s1 && ((cnt_q == '0) || ((cnt_q == CW'(1)) && out_ready));
	assign in_ready = !valid_s1 || xfer;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_enable_q <= 1'b0;
			map_low_q    <= '0;
			map_high_q   <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				dpce_pkg::CFG_MAP_ENABLE: map_enable_q <= cfg_data[0];
				dpce_pkg::CFG_MAP_LOW:    map_low_q    <= cfg_data[dpce_pkg::MAP_LOW_WIDTH-1:0];
				dpce_pkg::CFG_MAP_HIGH:   map_high_q   <= cfg_data[dpce_pkg::MAP_HIGH_WIDTH-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			sample_s1 <= in_word.sample;
			last_s1   <= in_word.last_sample;
		end
	end

	// coding of the word in the input register
	always_comb begin
		delta = sample_s1 - prev_q;
		neg   = delta[SW-1];
		mag   = neg ? ((SW+1)'(1) << SW) - {1'b0, delta} : {1'b0, delta};
		bin   = '0;
		for (int i = 0; i <= SW; i++) begin
			if (mag[i]) bin = BW'(i + 1);
		end
		idx_full = neg ? (((SW+1)'(1) << bin) - (SW+1)'(1) - mag) : mag;
		idx      = idx_full[SW-1:0];

		entries = {map_high_q, map_low_q};
		ent_pos = 7'(bin) * 7'(EW);
		ent_raw = entries[ent_pos +: EW];
		if (map_enable_q) code = (ent_raw > dpce_pkg::MAX_CODE) ? dpce_pkg::MAX_CODE : ent_raw;
		else code = bin;

		if (code == '0) begin
			pval = '0;
			plen = LW'(2);
		end else if (code < EW'(6)) begin
			pval = PW'(dpce_pkg::LOW_PREFIX[code[2:0]]);
			plen = LW'(3);
		end else begin
			plen = LW'(code - EW'(2));
			pval = PW'(((PW+1)'(1) << (plen - LW'(1))) - (PW+1)'(1));
		end

		pend_mask = pend_bits_q & 8'((9'd1 << pend_cnt_q) - 9'd1);
		acc = AW'(pend_mask) | (AW'(pval) << pend_cnt_q)
			| (AW'(idx) << (6'(pend_cnt_q) + 6'(plen)));
		added     = BW'(plen) + bin;
		ntot      = 6'(pend_cnt_q) + 6'(added);
		full      = ntot[5:3];
		pend_next = 8'(acc >> {full, 3'b000});

		sum       = {1'b0, bit_total_q} + (TBW+1)'(added);
		total_sat = sum[TBW] ? TOTAL_MAX : sum[TBW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q      <= '0;
			pend_bits_q <= '0;
			pend_cnt_q  <= '0;
			bit_total_q <= '0;
		end else if (xfer) begin
			if (last_s1) begin
				prev_q      <= '0;
				pend_bits_q <= '0;
				pend_cnt_q  <= '0;
				bit_total_q <= '0;
			end else begin
				prev_q      <= sample_s1;
				pend_bits_q <= pend_next;
				pend_cnt_q  <= ntot[2:0];
				bit_total_q <= total_sat;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (xfer) begin
			cnt_q <= CW'(full) + CW'(last_s1);
		end else if (out_valid && out_ready) begin
			cnt_q <= cnt_q - CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (xfer) begin
			acc_q   <= acc;
			last_q  <= last_s1;
			flush_q <= last_s1 && (ntot[2:0] != 3'd0);
			total_q <= total_sat;
		end else if (out_valid && out_ready) begin
			acc_q <= acc_q >> 8;
		end
	end

	assign out_valid  = cnt_q != '0;
	assign final_word = cnt_q == CW'(1);
	assign bare_end   = final_word && last_q && !flush_q;

	always_comb begin
		out_word.out_byte   = bare_end ? 8'd0 : acc_q[7:0];
		out_word.byte_valid = !bare_end;
		out_word.run_last   = final_word;
		out_word.block_end  = final_word && last_q;
		out_word.block_bits = (final_word && last_q) ? total_q : '0;
	end

	a_end_is_run_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_word.block_end |-> out_word.run_last)
		else $error("block end without run_last");

	a_bare_only_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_word.byte_valid |-> out_word.block_end && out_word.out_byte == 8'd0)
		else $error("empty word outside block end");

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(dpce_pkg::MAX_RESULTS))
		else $error("word count out of range");

	a_block_restart: assert property (@(posedge clk) disable iff (!arst_n)
		xfer && last_s1 |=> pend_cnt_q == 3'd0 && bit_total_q == '0 && prev_q == '0)
		else $error("state not cleared after block end");

endmodule
